// File: rtl/pfa_pkg.sv
// Shared types and constants for the partition fit allocator.
// Used by pfa_ctrl, pfa_dp and the top module in rtl/; depends on nothing.
package pfa_pkg;

    localparam int NUM_PARTITIONS = 16;
    localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);
    localparam int SIZE_W = 16;

    // APB register map
    localparam int PADDR_W = 3;
    localparam logic REG_FIT_MODE = 1'b0;
    localparam logic REG_BLOCKS_IN_USE = 1'b1;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_ALLOC = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } t_fit_mode;

    typedef enum logic [1:0] {
        ST_LOADED  = 2'd0,
        ST_GRANTED = 2'd1,
        ST_FAILED  = 2'd2
    } t_status;

    typedef struct packed {
        logic        command;
        logic [3:0]  block_index;
        logic [15:0] block_size;
        logic [7:0]  requester_id;
        logic [15:0] request_size;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] granted_index;
        logic [7:0] owner_id;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic issue;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic start_scan;
        logic last_issue;
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/pfa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/pfa_ctrl.sv
// Controller state machine for the partition fit allocator.
// Depends on pfa_pkg; drives the datapath through t_dp_cmd.
module pfa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pfa_pkg::t_dp_sts i_sts,
    output pfa_pkg::t_dp_cmd o_cmd
);

    pfa_pkg::t_state r_state;
    pfa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pfa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.start_scan ? pfa_pkg::S_SCAN : pfa_pkg::S_FINISH;
                end
            end
            pfa_pkg::S_SCAN: begin
                if (i_sts.last_issue) begin
                    n_state = pfa_pkg::S_DRAIN;
                end
            end
            pfa_pkg::S_DRAIN: begin
                n_state = pfa_pkg::S_FINISH;
            end
            pfa_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = pfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd = '0;
        case (r_state)
            pfa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            pfa_pkg::S_SCAN: begin
                o_cmd.issue = 1'b1;
            end
            pfa_pkg::S_DRAIN: begin
                o_cmd = '0;
            end
            pfa_pkg::S_FINISH: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/pfa_dp.sv
// Datapath: partition size RAM, taken marks, scan comparator and result register.
// Depends on pfa_pkg and pfa_ram; steered by pfa_ctrl.
module pfa_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfa_pkg::t_in_word   i_in_data,
    input  logic [1:0]          i_fit_mode,
    input  logic [4:0]          i_blocks_in_use,
    input  pfa_pkg::t_dp_cmd    i_cmd,
    output pfa_pkg::t_dp_sts    o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pfa_pkg::t_out_word  o_out_data
);

    localparam int IDX_W = pfa_pkg::IDX_W;
    localparam int CNT_W = pfa_pkg::CNT_W;
    localparam int SIZE_W = pfa_pkg::SIZE_W;

    // control state
    logic                         r_eval_vld;
    logic                         r_found;
    logic                         r_out_vld;
    logic [pfa_pkg::NUM_PARTITIONS-1:0] r_taken;

    // payload
    logic                         r_cmd;
    logic [3:0]                   r_bidx;
    logic [7:0]                   r_pid;
    logic [SIZE_W-1:0]            r_req;
    logic [CNT_W-1:0]             r_limit;
    logic [IDX_W-1:0]             r_scan_idx;
    logic [IDX_W-1:0]             r_eval_idx;
    logic [IDX_W-1:0]             r_best_idx;
    logic [SIZE_W-1:0]            r_best_size;
    pfa_pkg::t_out_word           r_out;
    pfa_pkg::t_out_word           n_out;

    logic [SIZE_W-1:0]            w_rd_data;
    logic                         w_load_ok;
    logic                         w_fits;
    logic                         w_update;
    logic [CNT_W-1:0]             w_limit;
    logic                         w_grant;

    assign w_load_ok = (i_in_data.command == pfa_pkg::CMD_LOAD) &&
                       (int'(i_in_data.block_index) < pfa_pkg::NUM_PARTITIONS);
    assign w_limit = (int'(i_blocks_in_use) > pfa_pkg::NUM_PARTITIONS) ?
                     CNT_W'(pfa_pkg::NUM_PARTITIONS) : CNT_W'(i_blocks_in_use);

    pfa_ram #(
        .WIDTH(SIZE_W),
        .DEPTH(pfa_pkg::NUM_PARTITIONS)
    ) u_size_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.accept && w_load_ok),
        .i_wr_addr (IDX_W'(i_in_data.block_index)),
        .i_wr_data (i_in_data.block_size),
        .i_rd_en   (i_cmd.issue),
        .i_rd_addr (r_scan_idx),
        .o_rd_data (w_rd_data)
    );

    // first fit keeps its first hit; best/worst replace on strict improvement
    assign w_fits = !r_taken[r_eval_idx] && (w_rd_data >= r_req);
    always_comb begin
        w_update = 1'b0;
        if (r_eval_vld && w_fits) begin
            if (!r_found) begin
                w_update = 1'b1;
            end else if (i_fit_mode == 2'(pfa_pkg::FIT_BEST)) begin
                w_update = w_rd_data < r_best_size;
            end else if (i_fit_mode == 2'(pfa_pkg::FIT_WORST)) begin
                w_update = w_rd_data > r_best_size;
            end
        end
    end

    assign w_grant = (r_cmd == pfa_pkg::CMD_ALLOC) && r_found;

    always_comb begin
        if (r_cmd == pfa_pkg::CMD_LOAD) begin
            n_out.status = 2'(pfa_pkg::ST_LOADED);
            n_out.granted_index = r_bidx;
            n_out.owner_id = '0;
        end else if (r_found) begin
            n_out.status = 2'(pfa_pkg::ST_GRANTED);
            n_out.granted_index = 4'(r_best_idx);
            n_out.owner_id = r_pid;
        end else begin
            n_out.status = 2'(pfa_pkg::ST_FAILED);
            n_out.granted_index = '0;
            n_out.owner_id = r_pid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval_vld <= 1'b0;
            r_found <= 1'b0;
            r_out_vld <= 1'b0;
            r_taken <= '0;
        end else begin
            r_eval_vld <= i_cmd.issue;
            if (i_cmd.accept) begin
                r_found <= 1'b0;
                if (w_load_ok) begin
                    r_taken[IDX_W'(i_in_data.block_index)] <= 1'b0;
                end
            end else if (w_update) begin
                r_found <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
                if (w_grant) begin
                    r_taken[r_best_idx] <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eval_idx <= r_scan_idx;
        if (i_cmd.accept) begin
            r_cmd <= i_in_data.command;
            r_bidx <= i_in_data.block_index;
            r_pid <= i_in_data.requester_id;
            r_req <= i_in_data.request_size;
            r_limit <= w_limit;
            r_scan_idx <= '0;
        end else if (i_cmd.issue) begin
            r_scan_idx <= r_scan_idx + 1'b1;
        end
        if (w_update) begin
            r_best_idx <= r_eval_idx;
            r_best_size <= w_rd_data;
        end
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_sts.start_scan = (i_in_data.command == pfa_pkg::CMD_ALLOC) &&
                              (i_blocks_in_use != '0);
    assign o_sts.last_issue = ((CNT_W'(r_scan_idx) + 1'b1) == r_limit);
    assign o_sts.out_free = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_out_data = r_out;

    // result register is only loaded once the previous word has left
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_vld || i_out_ready))
        else $error("result overwritten while still pending");

    // a granted partition is marked taken right after the result is built
    a_grant_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && w_grant) |=> r_taken[$past(r_best_idx)])
        else $error("granted partition not marked taken");

    // the scan never looks past the partitions in use
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eval_vld |-> (CNT_W'(r_eval_idx) < r_limit))
        else $error("scan evaluated partition outside limit");

endmodule

// File: rtl/partition_fit_allocator_top.sv
// Partition fit allocator: a table of fixed partitions with first/best/worst fit.
// Input word on i_in_*: command 0 loads one partition size and frees it, command 1
// allocates request_size for requester_id. One result word per input word on o_out_*.
// Registers over APB: fit_mode at 0x0, blocks_in_use at 0x4; write only while idle.
// A load, or an allocate with blocks_in_use of 0, goes from acceptance in S_IDLE
// to S_FINISH, which registers its result, and back to S_IDLE for the next word.
// An allocate reads one partition a cycle from a single-port-read size RAM with one
// comparator over the first min(blocks_in_use, 16) partitions, passing through S_SCAN
// and S_DRAIN before S_FINISH registers its result.
// The result register frees the input side: a new word is accepted while a result
// waits. If the receiver stalls, the block finishes the next word and then holds it
// until the pending result is taken; o_in_ready stays low meanwhile.
// Reset (i_rst_n low, synchronous) clears all taken marks, fit_mode and
// blocks_in_use; partition sizes are undefined until loaded and no clearing pass runs.
// Depends on pfa_pkg, pfa_ctrl, pfa_dp and pfa_ram.
module partition_fit_allocator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  pfa_pkg::t_in_word               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output pfa_pkg::t_out_word              o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pfa_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [1:0]       r_fit_mode;
    logic [4:0]       r_blocks_in_use;
    logic             w_cfg_wr;
    logic             w_reg_sel;
    pfa_pkg::t_dp_cmd w_cmd;
    pfa_pkg::t_dp_sts w_sts;

    assign pready = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= '0;
            r_blocks_in_use <= '0;
        end else if (w_cfg_wr) begin
            if (w_reg_sel == pfa_pkg::REG_FIT_MODE) begin
                r_fit_mode <= pwdata[1:0];
            end else begin
                r_blocks_in_use <= pwdata[4:0];
            end
        end
    end

    always_comb begin
        if (w_reg_sel == pfa_pkg::REG_BLOCKS_IN_USE) begin
            prdata = 32'(r_blocks_in_use);
        end else begin
            prdata = 32'(r_fit_mode);
        end
    end

    pfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pfa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_data       (i_in_data),
        .i_fit_mode      (r_fit_mode),
        .i_blocks_in_use (r_blocks_in_use),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_data      (o_out_data)
    );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for partition_fit_allocator_top: directed fit-policy cases,
// then random load/allocate traffic under random source gaps and sink stalls.
// Depends on pfa_pkg and the RTL top; results are checked against an in-bench predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FIT_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 2_000_000;

    logic                        i_clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    pfa_pkg::t_in_word           in_data;
    logic                        out_valid;
    logic                        out_ready;
    pfa_pkg::t_out_word          out_data;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [pfa_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    // predictor state
    logic [15:0]                 part_size [pfa_pkg::NUM_PARTITIONS];
    logic                        part_taken [pfa_pkg::NUM_PARTITIONS];
    logic [1:0]                  cur_mode;
    logic [4:0]                  cur_blocks;
    pfa_pkg::t_out_word          pending_results [$];

    int                          mismatches;
    int                          cycles;
    int                          ready_hold;
    bit                          quiet;

    partition_fit_allocator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // mostly short gaps, a few long ones; none in quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge i_clk) begin
        if (!rst_n) begin
            out_ready = 1'b0;
        end else if (quiet) begin
            out_ready = 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            out_ready = ($urandom_range(0, 3) != 0);
            ready_hold = pick_gap();
        end
    end

    function automatic pfa_pkg::t_out_word predict_result(pfa_pkg::t_in_word w);
        pfa_pkg::t_out_word r;
        int lim;
        int pick;
        r = '0;
        if (w.command == pfa_pkg::CMD_LOAD) begin
            part_size[w.block_index] = w.block_size;
            part_taken[w.block_index] = 1'b0;
            r.status = pfa_pkg::ST_LOADED;
            r.granted_index = w.block_index;
        end else begin
            lim = (cur_blocks > pfa_pkg::NUM_PARTITIONS) ?
                  pfa_pkg::NUM_PARTITIONS : int'(cur_blocks);
            pick = -1;
            for (int i = 0; i < lim; i++) begin
                if (!part_taken[i] && part_size[i] >= w.request_size) begin
                    if (pick < 0)
                        pick = i;
                    else if (cur_mode == pfa_pkg::FIT_BEST &&
                             part_size[i] < part_size[pick])
                        pick = i;
                    else if (cur_mode == pfa_pkg::FIT_WORST &&
                             part_size[i] > part_size[pick])
                        pick = i;
                end
            end
            if (pick >= 0) begin
                part_taken[pick] = 1'b1;
                r.status = pfa_pkg::ST_GRANTED;
                r.granted_index = pick[3:0];
            end else begin
                r.status = pfa_pkg::ST_FAILED;
            end
            r.owner_id = w.requester_id;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        pfa_pkg::t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result word with nothing pending: %h", $time, out_data);
            end else begin
                want = pending_results.pop_front();
                if (want.status != out_data.status) begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_data.status);
                end
                if (want.granted_index != out_data.granted_index) begin
                    mismatches++;
                    $display("%0t: granted_index expected %0d actual %0d",
                             $time, want.granted_index, out_data.granted_index);
                end
                if (want.owner_id != out_data.owner_id) begin
                    mismatches++;
                    $display("%0t: owner_id expected %0d actual %0d",
                             $time, want.owner_id, out_data.owner_id);
                end
            end
        end
    end

    // unused fields carry random bits
    function automatic pfa_pkg::t_in_word noise_word();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(pfa_pkg::t_in_word)-1:0];
    endfunction

    function automatic pfa_pkg::t_in_word load_word(logic [3:0] idx, logic [15:0] size);
        pfa_pkg::t_in_word w;
        w = noise_word();
        w.command = pfa_pkg::CMD_LOAD;
        w.block_index = idx;
        w.block_size = size;
        return w;
    endfunction

    function automatic pfa_pkg::t_in_word alloc_word(logic [7:0] pid, logic [15:0] req);
        pfa_pkg::t_in_word w;
        w = noise_word();
        w.command = pfa_pkg::CMD_ALLOC;
        w.requester_id = pid;
        w.request_size = req;
        return w;
    endfunction

    function automatic logic [15:0] random_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 16'($urandom_range(0, 63));
        if (r < 85)
            return 16'($urandom_range(0, 65535));
        return (r < 92) ? 16'd0 : 16'hFFFF;
    endfunction

    // requests mostly aim at sizes already in the table so that the policies matter
    function automatic pfa_pkg::t_in_word random_word();
        int r;
        int lim;
        logic [15:0] req;
        r = $urandom_range(0, 99);
        if (r < 40)
            return load_word(4'($urandom_range(0, 15)), random_size());
        lim = (cur_blocks > pfa_pkg::NUM_PARTITIONS) ?
              pfa_pkg::NUM_PARTITIONS : int'(cur_blocks);
        if (lim > 0 && r < 85) begin
            req = part_size[$urandom_range(0, lim - 1)];
            case ($urandom_range(0, 2))
                0: req = req - 16'd1;
                1: req = req + 16'd1;
                default: ;
            endcase
        end else begin
            req = random_size();
        end
        return alloc_word(8'($urandom_range(0, 255)), req);
    endfunction

    task automatic send_word(input pfa_pkg::t_in_word w);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data = w;
        do @(posedge i_clk); while (!in_ready);
        pending_results.push_back(predict_result(w));
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        drain();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == pfa_pkg::REG_FIT_MODE)
            cur_mode = value[1:0];
        else
            cur_blocks = value[4:0];
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_policy(input logic [1:0] mode, input logic [4:0] blocks);
        write_reg(pfa_pkg::REG_FIT_MODE, {30'd0, mode});
        write_reg(pfa_pkg::REG_BLOCKS_IN_USE, {27'd0, blocks});
    endtask

    // fill the whole table so no allocation ever scans an unloaded entry
    task automatic test_table_load();
        logic [15:0] size;
        for (int i = 0; i < pfa_pkg::NUM_PARTITIONS; i++) begin
            case (i)
                0: size = 16'd0;
                1, 3: size = 16'd300;
                2, 6, 13: size = 16'd100;
                4, 15: size = 16'hFFFF;
                5: size = 16'd50;
                default: size = random_size();
            endcase
            send_word(load_word(i[3:0], size));
        end
    endtask

    task automatic test_empty_table();
        send_word(alloc_word(8'd0, 16'd0));
        set_policy(pfa_pkg::FIT_FIRST, 5'd0);
        send_word(alloc_word(8'hFF, 16'd1));
    endtask

    task automatic test_fit_policies();
        set_policy(pfa_pkg::FIT_FIRST, 5'd16);
        send_word(alloc_word(8'd1, 16'd100));
        write_reg(pfa_pkg::REG_FIT_MODE, {30'd0, pfa_pkg::FIT_BEST});
        send_word(alloc_word(8'd2, 16'd100));
        send_word(alloc_word(8'd3, 16'd100));
        write_reg(pfa_pkg::REG_FIT_MODE, {30'd0, pfa_pkg::FIT_WORST});
        send_word(alloc_word(8'd4, 16'd0));
    endtask

    task automatic test_edge_cases();
        // largest possible request still finds a free max-size partition
        send_word(alloc_word(8'hFF, 16'hFFFF));
        // unused mode falls back to first fit; zero request takes a zero-size entry
        write_reg(pfa_pkg::REG_FIT_MODE, {30'd0, FIT_UNUSED});
        send_word(alloc_word(8'h80, 16'd0));
        // over-range count clamps to the table
        set_policy(pfa_pkg::FIT_WORST, 5'd31);
        send_word(alloc_word(8'h7F, 16'hFFFF));
        send_word(load_word(4'd4, 16'hFFFF));
        send_word(alloc_word(8'h55, 16'hFFFF));
    endtask

    task automatic test_random_traffic();
        logic [1:0] mode;
        logic [4:0] blocks;
        int count;
        for (int p = 0; p < 9; p++) begin
            quiet = 1'b0;
            count = 200;
            case (p)
                0: begin mode = pfa_pkg::FIT_FIRST; blocks = 5'd16; quiet = 1'b1; end
                1: begin mode = pfa_pkg::FIT_BEST;  blocks = 5'd16; count = 260; end
                2: begin mode = pfa_pkg::FIT_WORST; blocks = 5'd16; count = 260; end
                3: begin mode = FIT_UNUSED;         blocks = 5'd9; end
                4: begin mode = pfa_pkg::FIT_BEST;  blocks = 5'd31; end
                5: begin mode = pfa_pkg::FIT_WORST; blocks = 5'd1;  count = 150; end
                6: begin mode = pfa_pkg::FIT_FIRST; blocks = 5'd0;  count = 80; end
                7: begin
                    mode = 2'($urandom_range(0, 3));
                    blocks = 5'($urandom_range(0, 20));
                end
                default: begin mode = pfa_pkg::FIT_BEST; blocks = 5'd16; quiet = 1'b1; end
            endcase
            set_policy(mode, blocks);
            repeat (count) send_word(random_word());
        end
        quiet = 1'b0;
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet = 1'b0;
        ready_hold = 0;
        mismatches = 0;
        cycles = 0;
        cur_mode = pfa_pkg::FIT_FIRST;
        cur_blocks = '0;
        for (int i = 0; i < pfa_pkg::NUM_PARTITIONS; i++) begin
            part_size[i] = '0;
            part_taken[i] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        rst_n = 1'b1;

        test_table_load();
        test_empty_table();
        test_fit_policies();
        test_edge_cases();
        test_random_traffic();

        drain();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
